FILE: src/psum_pkg.sv
`default_nettype none

package psum_pkg;

   // default width of the bound
   localparam int BOUND_WIDTH_DEF = 16;

   // width of the running and reported sum
   localparam int TOTAL_WIDTH = 32;

   // smallest prime, counted apart from the odd candidates
   localparam int FIRST_PRIME = 2;

   // sequencer state codes
   localparam int STATE_WIDTH = 3;
   localparam logic [STATE_WIDTH-1:0] ST_IDLE  = 3'd0;
   localparam logic [STATE_WIDTH-1:0] ST_CAND  = 3'd1;
   localparam logic [STATE_WIDTH-1:0] ST_NEXT  = 3'd2;
   localparam logic [STATE_WIDTH-1:0] ST_CHECK = 3'd3;
   localparam logic [STATE_WIDTH-1:0] ST_DIV   = 3'd4;

endpackage : psum_pkg

`default_nettype wire

FILE: src/prime_sum_up_to_n.sv
`default_nettype none
// Sum of all primes not above req_bound, by trial division with a table of found primes.
// Each odd candidate k from 3 up to the bound is tried against the stored primes p with
// p*p <= k in turn, by a bit-serial restoring division; k is composite on a zero remainder and
// prime when the stored primes run out or the next one squared exceeds k.
// One item at a time; busy is high meanwhile. rsp_valid lasts one cycle, no stall.
// Reset (synchronous) returns the sequencer to idle; the prime table needs no clearing.
module prime_sum_up_to_n #(
   parameter int BOUND_WIDTH = psum_pkg::BOUND_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [BOUND_WIDTH-1:0]           req_bound,
   output logic                                  rsp_valid,
   output logic [psum_pkg::TOTAL_WIDTH-1:0]      rsp_prime_total
);
   import psum_pkg::*;

   // width of the table entries: primes whose square can stay within the bound
   localparam int HALF_WIDTH = (BOUND_WIDTH + 1) / 2;
   localparam int IDX_WIDTH  = (HALF_WIDTH > 1) ? HALF_WIDTH - 1 : 1;
   localparam int DEPTH      = 2 ** IDX_WIDTH;
   localparam int CAND_WIDTH = BOUND_WIDTH + 1;
   localparam int SQ_WIDTH   = 2 * HALF_WIDTH + 1;
   localparam int DCNT_WIDTH = $clog2(BOUND_WIDTH + 1);
   localparam logic [DCNT_WIDTH-1:0] DIV_LAST = DCNT_WIDTH'(BOUND_WIDTH - 1);

   // prime table memory
   logic [HALF_WIDTH-1:0] mem_ff [DEPTH];
   logic [HALF_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic [IDX_WIDTH-1:0]  mem_rd_addr;

   logic [STATE_WIDTH-1:0] state_ff, state_in;
   logic [BOUND_WIDTH-1:0] bound_ff, bound_in;
   logic [CAND_WIDTH-1:0]  cand_ff, cand_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [IDX_WIDTH-1:0]   count_ff, count_in;
   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [HALF_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [HALF_WIDTH-1:0]  rem_ff, rem_in;
   logic [BOUND_WIDTH-1:0] quo_ff, quo_in;
   logic [DCNT_WIDTH-1:0]  dcnt_ff, dcnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_WIDTH-1:0] rsp_total_ff, rsp_total_in;

   logic                   accept;
   logic                   found_prime;
   logic                   small_cand;
   logic [SQ_WIDTH-1:0]    square;
   logic [HALF_WIDTH:0]    shifted;
   logic [HALF_WIDTH:0]    trial;
   logic [HALF_WIDTH-1:0]  rem_next;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // square of the prime just read, against the candidate
   assign square = SQ_WIDTH'({1'b0, rd_data_ff}) * SQ_WIDTH'({1'b0, rd_data_ff});

   // candidate fits a table entry
   assign small_cand = ((cand_ff >> HALF_WIDTH) == '0);

   // one restoring step of the remainder
   assign shifted  = {rem_ff, quo_ff[BOUND_WIDTH-1]};
   assign trial    = shifted - {1'b0, divisor_ff};
   assign rem_next = (shifted >= {1'b0, divisor_ff}) ? trial[HALF_WIDTH-1:0]
                                                     : shifted[HALF_WIDTH-1:0];

   // decide: no stored prime left, or the next one is above the square root
   always_comb begin
      found_prime = 1'b0;
      if (state_ff == ST_NEXT && idx_ff == count_ff) begin
         found_prime = 1'b1;
      end else if (state_ff == ST_CHECK &&
                   square > SQ_WIDTH'(cand_ff)) begin
         found_prime = 1'b1;
      end
   end

   assign mem_we      = found_prime && small_cand;
   assign mem_rd_addr = idx_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bound_in     = bound_ff;
      cand_in      = cand_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bound_in = req_bound;
               cand_in  = CAND_WIDTH'(3);
               count_in = '0;
               total_in = (req_bound >= BOUND_WIDTH'(FIRST_PRIME)) ?
                          TOTAL_WIDTH'(FIRST_PRIME) : '0;
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (cand_ff > CAND_WIDTH'(bound_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = '0;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (!found_prime) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!found_prime) begin
               divisor_in = rd_data_ff;
               rem_in     = '0;
               quo_in     = cand_ff[BOUND_WIDTH-1:0];
               dcnt_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = rem_next;
            quo_in  = quo_ff << 1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_LAST) begin
               if (rem_next == '0) begin
                  // composite: drop it
                  cand_in  = cand_ff + CAND_WIDTH'(2);
                  state_in = ST_CAND;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_NEXT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // prime found: add it, keep it when small, advance
      if (found_prime) begin
         total_in = total_ff + TOTAL_WIDTH'(cand_ff);
         if (small_cand) begin
            count_in = count_ff + 1'b1;
         end
         cand_in  = cand_ff + CAND_WIDTH'(2);
         state_in = ST_CAND;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      bound_ff     <= bound_in;
      cand_ff      <= cand_in;
      total_ff     <= total_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      rsp_total_ff <= rsp_total_in;
   end

   // prime table: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[count_ff] <= cand_ff[HALF_WIDTH-1:0];
      end
      rd_data_ff <= mem_ff[mem_rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_total = rsp_total_ff;

endmodule : prime_sum_up_to_n

`default_nettype wire

FILE: test/prime_sum_up_to_n_tb.sv
`timescale 1ns / 100ps

module prime_sum_up_to_n_tb;

   import psum_pkg::*;

   localparam int BW          = BOUND_WIDTH_DEF;
   localparam int RAND_BEATS  = 100;
   localparam int DRAIN_CYCLES = 200;

   // one row of the directed part: a bound and, where it is obvious, its total
   typedef struct packed {
      logic [BW-1:0]          bound;
      bit                     fixed;
      logic [TOTAL_WIDTH-1:0] total;
   } bound_row_type;

   localparam int DIR_ROWS = 16;

   bound_row_type bound_rows [DIR_ROWS] = '{
      '{16'd0,      1'b1, 32'd0},
      '{16'd1,      1'b1, 32'd0},
      '{16'd2,      1'b1, 32'd2},
      '{16'd3,      1'b1, 32'd5},
      '{16'd4,      1'b1, 32'd5},
      '{16'd5,      1'b1, 32'd10},
      '{16'd9,      1'b0, 32'd0},
      '{16'd25,     1'b0, 32'd0},
      '{16'd49,     1'b0, 32'd0},
      '{16'd97,     1'b0, 32'd0},
      '{16'd255,    1'b0, 32'd0},
      '{16'd256,    1'b0, 32'd0},
      '{16'd1000,   1'b0, 32'd0},
      '{16'h0AAA,   1'b0, 32'd0},
      '{16'h0555,   1'b0, 32'd0},
      '{16'hFFFF,   1'b1, 32'd202288087}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic [BW-1:0]          req_bound = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [TOTAL_WIDTH-1:0] rsp_prime_total;

   logic [TOTAL_WIDTH-1:0] pending_totals [$];
   int                     err_count = 0;
   int                     calm_left = 0;

   prime_sum_up_to_n #(
      .BOUND_WIDTH(BW)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_bound       (req_bound),
      .rsp_valid       (rsp_valid),
      .rsp_prime_total (rsp_prime_total)
   );

   always #1 clock = ~clock;

   // sum every prime not above n, each counted once
   function automatic logic [TOTAL_WIDTH-1:0] prime_sum_upto(input logic [BW-1:0] n);
      logic [TOTAL_WIDTH-1:0] total;
      int unsigned            k;
      int unsigned            d;
      bit                     is_prime;
      total = '0;
      for (k = FIRST_PRIME; k <= n; k++) begin
         is_prime = 1'b1;
         for (d = FIRST_PRIME; d * d <= k; d++) begin
            if (k % d == 0) begin
               is_prime = 1'b0;
               break;
            end
         end
         if (is_prime)
            total = total + k;
      end
      return total;
   endfunction

   // mostly back-to-back or short gaps, now and then a long one, with calm stretches
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left = $urandom_range(4, 12);
         return 0;
      end
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 200);
   endfunction

   // keep most bounds small, since run time grows fast with the bound
   function automatic logic [BW-1:0] pick_bound();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return BW'($urandom_range(0, 5));
      if (r < 70)
         return BW'($urandom_range(0, 127));
      if (r < 95)
         return BW'($urandom_range(128, 1023));
      return BW'($urandom_range(1024, 4095));
   endfunction

   // present one bound, hold it until it is taken, record its total
   task automatic issue_bound(input logic [BW-1:0] b, input bit fixed,
                              input logic [TOTAL_WIDTH-1:0] fixed_total);
      logic [TOTAL_WIDTH-1:0] expected;
      int                     gap;
      expected = fixed ? fixed_total : prime_sum_upto(b);
      start     <= 1'b1;
      req_bound <= b;
      do
         @(posedge clock);
      while (busy);
      pending_totals.push_back(expected);
      gap = pick_gap();
      if (gap > 0) begin
         start     <= 1'b0;
         req_bound <= BW'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // compare each result beat with the oldest pending total
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_totals.size() == 0) begin
            $error("unexpected result beat: prime_total %0d", rsp_prime_total);
            err_count++;
         end else begin
            if (rsp_prime_total !== pending_totals[0]) begin
               $error("prime_total mismatch: expected %0d, actual %0d",
                      pending_totals[0], rsp_prime_total);
               err_count++;
            end
            void'(pending_totals.pop_front());
         end
      end
   end

   // main sequence: reset, directed rows, random bounds, drain
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         issue_bound(bound_rows[i].bound, bound_rows[i].fixed, bound_rows[i].total);

      for (int i = 0; i < RAND_BEATS; i++)
         issue_bound(pick_bound(), 1'b0, '0);

      start <= 1'b0;
      while (pending_totals.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0 && pending_totals.size() == 0) begin
         $display("prime_sum_up_to_n_tb: done, clean");
      end else begin
         $display("prime_sum_up_to_n_tb: done, errors");
      end
      $finish;
   end

   // watchdog: allow the largest bound several times over
   initial begin
      #400_000_000;
      $display("prime_sum_up_to_n_tb: done, errors");
      $finish;
   end

endmodule
